FILE: sv/ctcp_pkg.sv
package ctcp_pkg;

    // Console characters the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_V  = 8'h76;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // First letter codes
    localparam logic [2:0] LET_NONE = 3'd0;
    localparam logic [2:0] LET_S    = 3'd1;
    localparam logic [2:0] LET_R    = 3'd2;
    localparam logic [2:0] LET_Z    = 3'd3;
    localparam logic [2:0] LET_D    = 3'd4;
    localparam logic [2:0] LET_T    = 3'd5;
    localparam logic [2:0] LET_V    = 3'd6;

    // Command codes
    localparam logic [3:0] CMD_NONE = 4'd0;
    localparam logic [3:0] CMD_ST   = 4'd1;
    localparam logic [3:0] CMD_RT   = 4'd2;
    localparam logic [3:0] CMD_Z1   = 4'd3;
    localparam logic [3:0] CMD_Z2   = 4'd4;
    localparam logic [3:0] CMD_D1   = 4'd5;
    localparam logic [3:0] CMD_D2   = 4'd6;
    localparam logic [3:0] CMD_T1   = 4'd7;
    localparam logic [3:0] CMD_T2   = 4'd8;
    localparam logic [3:0] CMD_V1   = 4'd9;
    localparam logic [3:0] CMD_V2   = 4'd10;

    // Value limits
    localparam int VALUE_W = 15;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 15'd32767;

    // Command queue between parser and executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Ceil(2^38 / 100): exact quotient by 100 for dividends below 2^31
    localparam logic [63:0] RECIP_100   = 64'd2748779070;
    localparam int          RECIP_SHIFT = 38;

    // Parsed command handed to the executor
    typedef struct packed {
        logic [3:0]         code;
        logic signed [15:0] value;
    } ctcp_cmd_t;

    // Result payload, ratio in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic signed [23:0] compare_master;
        logic signed [23:0] compare_b3;
        logic signed [18:0] compare_b2;
        logic signed [17:0] compare_b1;
        logic signed [23:0] compare_a3;
        logic signed [18:0] compare_a2;
        logic signed [17:0] compare_a1;
        logic signed [15:0] ratio;
    } ctcp_result_t;

    localparam int RESULT_W = $bits(ctcp_result_t);

endpackage

FILE: sv/ctcp_front.sv
module ctcp_front #(
    parameter int MAX_LINE = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        char_in,
    input  logic              end_of_line,
    output logic              cmd_push,
    output ctcp_pkg::ctcp_cmd_t cmd_data
);

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(MAX_LINE - 1);

    logic [2:0]                    first_letter_reg, first_letter_next;
    logic [3:0]                    command_reg, command_next;
    logic                          equal_seen_reg, equal_seen_next;
    logic                          minus_seen_reg, minus_seen_next;
    logic [ctcp_pkg::VALUE_W-1:0]  value_acc_reg, value_acc_next;
    logic                          leading_done_reg, leading_done_next;
    logic                          token_done_reg, token_done_next;
    logic [CNT_W-1:0]              char_count_reg, char_count_next;
    logic [18:0]                   acc_x10;
    logic                          is_space;
    logic                          is_digit;

    assign is_space = (char_in == ctcp_pkg::CH_SPACE) || (char_in == ctcp_pkg::CH_TAB) ||
                      (char_in == ctcp_pkg::CH_CR) || (char_in == ctcp_pkg::CH_LF);
    assign is_digit = (char_in >= ctcp_pkg::CH_ZERO) && (char_in <= ctcp_pkg::CH_NINE);
    assign acc_x10  = 19'(value_acc_reg) * 19'd10 + 19'(char_in - ctcp_pkg::CH_ZERO);

    // Byte parse and end-of-line dispatch
    always_comb begin
        first_letter_next = first_letter_reg;
        command_next      = command_reg;
        equal_seen_next   = equal_seen_reg;
        minus_seen_next   = minus_seen_reg;
        value_acc_next    = value_acc_reg;
        leading_done_next = leading_done_reg;
        token_done_next   = token_done_reg;
        char_count_next   = char_count_reg;
        cmd_push          = 1'b0;
        cmd_data.code     = command_reg;
        cmd_data.value    = 16'sd0;

        if (in_accept) begin
            if (char_count_reg < LINE_LIMIT) begin
                char_count_next = char_count_reg + 1'b1;
                if (!token_done_reg) begin
                    if (char_in == ctcp_pkg::CH_NUL) begin
                        token_done_next = 1'b1;
                    end else if (is_space) begin
                        if (leading_done_reg) begin
                            token_done_next = 1'b1;
                        end
                    end else begin
                        leading_done_next = 1'b1;
                        if (first_letter_reg == ctcp_pkg::LET_NONE) begin
                            case (char_in)
                                ctcp_pkg::CH_LC_S: first_letter_next = ctcp_pkg::LET_S;
                                ctcp_pkg::CH_LC_R: first_letter_next = ctcp_pkg::LET_R;
                                ctcp_pkg::CH_LC_Z: first_letter_next = ctcp_pkg::LET_Z;
                                ctcp_pkg::CH_LC_D: first_letter_next = ctcp_pkg::LET_D;
                                ctcp_pkg::CH_LC_T: first_letter_next = ctcp_pkg::LET_T;
                                ctcp_pkg::CH_LC_V: first_letter_next = ctcp_pkg::LET_V;
                                default:           first_letter_next = ctcp_pkg::LET_NONE;
                            endcase
                        end else if (equal_seen_reg) begin
                            if (is_digit) begin
                                value_acc_next = (acc_x10 > 19'(ctcp_pkg::VALUE_MAX)) ?
                                                 ctcp_pkg::VALUE_MAX : acc_x10[14:0];
                            end else if (char_in == ctcp_pkg::CH_MINUS) begin
                                minus_seen_next = 1'b1;
                            end
                        end else if (command_reg != ctcp_pkg::CMD_NONE) begin
                            if (char_in == ctcp_pkg::CH_EQUAL) begin
                                equal_seen_next = 1'b1;
                            end
                        end else if (first_letter_reg == ctcp_pkg::LET_S) begin
                            command_next = ctcp_pkg::CMD_ST;
                        end else if (first_letter_reg == ctcp_pkg::LET_R) begin
                            command_next = ctcp_pkg::CMD_RT;
                        end else if (char_in == ctcp_pkg::CH_ONE ||
                                     char_in == ctcp_pkg::CH_TWO) begin
                            case (first_letter_reg)
                                ctcp_pkg::LET_Z: command_next = (char_in == ctcp_pkg::CH_ONE) ?
                                                 ctcp_pkg::CMD_Z1 : ctcp_pkg::CMD_Z2;
                                ctcp_pkg::LET_D: command_next = (char_in == ctcp_pkg::CH_ONE) ?
                                                 ctcp_pkg::CMD_D1 : ctcp_pkg::CMD_D2;
                                ctcp_pkg::LET_T: command_next = (char_in == ctcp_pkg::CH_ONE) ?
                                                 ctcp_pkg::CMD_T1 : ctcp_pkg::CMD_T2;
                                ctcp_pkg::LET_V: command_next = (char_in == ctcp_pkg::CH_ONE) ?
                                                 ctcp_pkg::CMD_V1 : ctcp_pkg::CMD_V2;
                                default:         command_next = ctcp_pkg::CMD_NONE;
                            endcase
                        end
                    end
                end
            end

            // Line ends: hand a complete command over, then clear the parse
            if (end_of_line) begin
                cmd_push = equal_seen_next && (command_next != ctcp_pkg::CMD_NONE) &&
                           (command_next <= ctcp_pkg::CMD_V2);
                cmd_data.code  = command_next;
                cmd_data.value = minus_seen_next ? 16'sd0 - $signed({1'b0, value_acc_next}) :
                                                   $signed({1'b0, value_acc_next});
                first_letter_next = ctcp_pkg::LET_NONE;
                command_next      = ctcp_pkg::CMD_NONE;
                equal_seen_next   = 1'b0;
                minus_seen_next   = 1'b0;
                value_acc_next    = '0;
                leading_done_next = 1'b0;
                token_done_next   = 1'b0;
                char_count_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_letter_reg <= ctcp_pkg::LET_NONE;
            command_reg      <= ctcp_pkg::CMD_NONE;
            equal_seen_reg   <= 1'b0;
            minus_seen_reg   <= 1'b0;
            value_acc_reg    <= '0;
            leading_done_reg <= 1'b0;
            token_done_reg   <= 1'b0;
            char_count_reg   <= '0;
        end else begin
            first_letter_reg <= first_letter_next;
            command_reg      <= command_next;
            equal_seen_reg   <= equal_seen_next;
            minus_seen_reg   <= minus_seen_next;
            value_acc_reg    <= value_acc_next;
            leading_done_reg <= leading_done_next;
            token_done_reg   <= token_done_next;
            char_count_reg   <= char_count_next;
        end
    end

endmodule

FILE: sv/ctcp_queue.sv
module ctcp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ctcp_pkg::ctcp_cmd_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                pop_valid,
    output ctcp_pkg::ctcp_cmd_t pop_data
);

    ctcp_pkg::ctcp_cmd_t entries [ctcp_pkg::QUEUE_DEPTH];

    logic [ctcp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ctcp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ctcp_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full      = (count_reg == (ctcp_pkg::QPTR_W + 1)'(ctcp_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/ctcp_back.sv
module ctcp_back #(
    parameter int PERIOD_COUNT  = 16384,
    parameter int COUNTS_PER_NS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    input  ctcp_pkg::ctcp_cmd_t             cmd_data,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctcp_pkg::RESULT_W-1:0]   m_tdata,
    output logic [0:0]                      m_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic signed [15:0] RATIO_RST = 16'sd10;
    localparam logic signed [23:0] BASE_RST  = 24'(PERIOD_COUNT * 10 / 100);
    localparam logic signed [17:0] WIDTH_RST = 18'(150 * COUNTS_PER_NS);
    localparam logic signed [17:0] DLOW_RST  = 18'(-20 * COUNTS_PER_NS);
    localparam logic signed [17:0] DHIGH_RST = 18'(-5 * COUNTS_PER_NS);
    localparam logic [23:0]        PERIOD24  = 24'(PERIOD_COUNT);

    logic [1:0]         state_reg, state_next;
    logic               status_reg, status_next;
    logic signed [15:0] ratio_reg, ratio_next;
    logic signed [23:0] base_reg, base_next;
    logic signed [17:0] width_low_reg, width_low_next;
    logic signed [17:0] width_high_reg, width_high_next;
    logic signed [17:0] delay_low_reg, delay_low_next;
    logic signed [17:0] delay_high_reg, delay_high_next;
    logic signed [17:0] trail_low_reg, trail_low_next;
    logic signed [17:0] trail_high_reg, trail_high_next;
    logic [31:0]        prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic               out_valid_reg, out_valid_next;
    ctcp_pkg::ctcp_result_t out_data_reg, out_data_next;
    logic               out_status_reg, out_status_next;

    logic signed [31:0] scaled;
    logic signed [17:0] cnt;
    logic signed [16:0] ratio_wide;
    logic [16:0]        ratio_mag;
    logic [63:0]        recip_prod;
    logic [23:0]        quot;
    logic               out_free;

    assign scaled     = 32'(cmd_data.value) * 32'(COUNTS_PER_NS);
    assign cnt        = scaled[17:0];
    assign ratio_wide = 17'(ratio_reg);
    assign ratio_mag  = ratio_wide[16] ? 17'(-ratio_wide) : 17'(ratio_wide);
    assign recip_prod = {32'd0, prod_reg} * ctcp_pkg::RECIP_100;
    assign quot       = recip_prod[ctcp_pkg::RECIP_SHIFT +: 24];
    assign out_free   = !out_valid_reg || m_tready;
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;

    // Command sequencer: apply setting, rebuild base for rt, then load result
    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        ratio_next      = ratio_reg;
        base_next       = base_reg;
        width_low_next  = width_low_reg;
        width_high_next = width_high_reg;
        delay_low_next  = delay_low_reg;
        delay_high_next = delay_high_reg;
        trail_low_next  = trail_low_reg;
        trail_high_next = trail_high_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    status_next = (cmd_data.code == ctcp_pkg::CMD_ST);
                    state_next  = ST_EMIT;
                    case (cmd_data.code)
                        ctcp_pkg::CMD_RT: begin
                            ratio_next = cmd_data.value;
                            state_next = ST_MUL;
                        end
                        ctcp_pkg::CMD_Z1: width_low_next  = cnt;
                        ctcp_pkg::CMD_Z2: width_high_next = cnt;
                        ctcp_pkg::CMD_D1: delay_low_next  = cnt;
                        ctcp_pkg::CMD_D2: delay_high_next = cnt;
                        ctcp_pkg::CMD_T1: trail_low_next  = cnt;
                        ctcp_pkg::CMD_T2: trail_high_next = cnt;
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                prod_next  = 32'(ratio_mag) * 32'(PERIOD_COUNT);
                neg_next   = ratio_reg[15];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // quotient truncates toward zero, sign restored afterwards
                base_next  = neg_reg ? 24'sd0 - $signed(quot) : $signed(quot);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next                = 1'b1;
                    out_status_next               = status_reg;
                    out_data_next.pad             = '0;
                    out_data_next.ratio           = ratio_reg;
                    out_data_next.compare_a1      = width_low_reg;
                    out_data_next.compare_a2      = 19'(width_low_reg) + 19'(delay_low_reg);
                    out_data_next.compare_a3      = PERIOD24 - base_reg + 24'(trail_low_reg);
                    out_data_next.compare_b1      = width_high_reg;
                    out_data_next.compare_b2      = 19'(width_high_reg) + 19'(delay_high_reg);
                    out_data_next.compare_b3      = base_reg + 24'(trail_high_reg);
                    out_data_next.compare_master  = PERIOD24 - base_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            ratio_reg      <= RATIO_RST;
            base_reg       <= BASE_RST;
            width_low_reg  <= WIDTH_RST;
            width_high_reg <= WIDTH_RST;
            delay_low_reg  <= DLOW_RST;
            delay_high_reg <= DHIGH_RST;
            trail_low_reg  <= '0;
            trail_high_reg <= '0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            ratio_reg      <= ratio_next;
            base_reg       <= base_next;
            width_low_reg  <= width_low_next;
            width_high_reg <= width_high_next;
            delay_low_reg  <= delay_low_next;
            delay_high_reg <= delay_high_next;
            trail_low_reg  <= trail_low_next;
            trail_high_reg <= trail_high_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: sv/console_timing_command_parser.sv
// Console command parser for the inverter timing compares. Takes one console byte per
// transfer (tlast marks the final byte of a line) and accepts a byte in every cycle while
// its two-entry command queue has room. Commands are "xy=value": rt sets ratio and base,
// z1/z2 pulse widths, d1/d2 delays, t1/t2 trailing counts (ns times COUNTS_PER_NS), st
// requests a status snapshot, v1/v2 are accepted but change nothing. A line that ends on a
// complete command yields one result transfer with all seven compare values; other lines
// yield none. The result passes through the command queue and the executor's idle and
// emit states, for rt also through its multiply state, which forms the ratio times period
// product, and its divide state, whose reciprocal multiply divides it by 100. The
// executor takes a command only once the last result is loaded. The queue holds the input
// back once full, which takes a stalled result register or rt lines under four bytes.
module console_timing_command_parser #(
    parameter int PERIOD_COUNT  = 16384,
    parameter int COUNTS_PER_NS = 4,
    parameter int MAX_LINE      = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_in[7:0]
    input  logic         s_tlast,   // end_of_line
    output logic         m_tvalid,
    input  logic         m_tready,
    // ratio[15:0], compare_a1[33:16], compare_a2[52:34], compare_a3[76:53],
    // compare_b1[94:77], compare_b2[113:95], compare_b3[137:114],
    // compare_master[161:138], zero fill[167:162]
    output logic [167:0] m_tdata,
    output logic [0:0]   m_tuser    // status
);

    ctcp_pkg::ctcp_cmd_t push_data;
    ctcp_pkg::ctcp_cmd_t pop_data;
    logic                push;
    logic                pop;
    logic                full;
    logic                pop_valid;
    logic                in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && !full;

    ctcp_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .char_in     (s_tdata),
        .end_of_line (s_tlast),
        .cmd_push    (push),
        .cmd_data    (push_data)
    );

    ctcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    ctcp_back #(
        .PERIOD_COUNT  (PERIOD_COUNT),
        .COUNTS_PER_NS (COUNTS_PER_NS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_data  (pop_data),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: sim/ctcp_timing_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the parser and the timing
// registers, and compares every result transfer with the oldest predicted snapshot.
module ctcp_timing_checker
    import ctcp_pkg::*;
#(
    parameter int PERIOD_COUNT  = 16384,
    parameter int COUNTS_PER_NS = 4,
    parameter int MAX_LINE      = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [RESULT_W-1:0] m_tdata,
    input  logic [0:0]          m_tuser,
    output int                  error_count,
    output int                  pending_count,
    output int                  result_count
);

    typedef struct {
        logic         status;
        ctcp_result_t fields;
    } snapshot_t;

    snapshot_t snapshots_due[$];

    // Line parse state
    logic [2:0]  first_letter;
    logic [3:0]  command;
    bit          equal_seen;
    bit          minus_seen;
    bit          leading_done;
    bit          token_done;
    int unsigned value_acc;
    int unsigned char_count;

    // Timing registers
    logic [15:0] ratio_reg;
    logic [23:0] base_count;
    logic [17:0] width_lo, width_hi, delay_lo, delay_hi, trail_lo, trail_hi;

    int errors = 0;
    int results = 0;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function void clear_line();
        first_letter = LET_NONE;
        command      = CMD_NONE;
        equal_seen   = 1'b0;
        minus_seen   = 1'b0;
        leading_done = 1'b0;
        token_done   = 1'b0;
        value_acc    = 0;
        char_count   = 0;
    endfunction

    // Ratio in percent; base is ratio * period / 100, truncated toward zero
    function void apply_ratio(logic [15:0] r);
        longint product;
        ratio_reg  = r;
        product    = longint'($signed(r));
        product    = product * PERIOD_COUNT;
        base_count = 24'(product / 100);
    endfunction

    function void timing_reset();
        clear_line();
        apply_ratio(16'd10);
        width_lo = 18'(150 * COUNTS_PER_NS);
        width_hi = 18'(150 * COUNTS_PER_NS);
        delay_lo = 18'(-20 * COUNTS_PER_NS);
        delay_hi = 18'(-5 * COUNTS_PER_NS);
        trail_lo = '0;
        trail_hi = '0;
    endfunction

    // One byte of the token scanner
    function void scan_char(logic [7:0] c);
        int unsigned next_acc;
        if (token_done)
            return;
        if (c == CH_NUL) begin
            token_done = 1'b1;
            return;
        end
        if (is_blank(c)) begin
            if (leading_done)
                token_done = 1'b1;
            return;
        end
        leading_done = 1'b1;
        if (first_letter == LET_NONE) begin
            case (c)
                CH_LC_S: first_letter = LET_S;
                CH_LC_R: first_letter = LET_R;
                CH_LC_Z: first_letter = LET_Z;
                CH_LC_D: first_letter = LET_D;
                CH_LC_T: first_letter = LET_T;
                CH_LC_V: first_letter = LET_V;
                default: ;
            endcase
        end else if (equal_seen) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                next_acc  = value_acc * 10 + int'(c - CH_ZERO);
                value_acc = (next_acc > VALUE_MAX) ? VALUE_MAX : next_acc;
            end else if (c == CH_MINUS) begin
                minus_seen = 1'b1;
            end
        end else if (command != CMD_NONE) begin
            if (c == CH_EQUAL)
                equal_seen = 1'b1;
        end else if (first_letter == LET_S) begin
            command = CMD_ST;
        end else if (first_letter == LET_R) begin
            command = CMD_RT;
        end else if (c == CH_ONE || c == CH_TWO) begin
            case (first_letter)
                LET_Z:   command = (c == CH_ONE) ? CMD_Z1 : CMD_Z2;
                LET_D:   command = (c == CH_ONE) ? CMD_D1 : CMD_D2;
                LET_T:   command = (c == CH_ONE) ? CMD_T1 : CMD_T2;
                default: command = (c == CH_ONE) ? CMD_V1 : CMD_V2;
            endcase
        end
    endfunction

    // Accepted byte: parse, and on end of line execute and predict the snapshot
    function void take_char(logic [7:0] c, logic eol);
        logic [3:0]  cmd;
        longint      val;
        logic [17:0] counts;
        longint      bs, wl, wh, dl, dh, tl, th;
        snapshot_t   snap;
        if (char_count < MAX_LINE - 1) begin
            char_count++;
            scan_char(c);
        end
        if (!eol)
            return;
        cmd = command;
        if (!equal_seen || cmd == CMD_NONE || cmd > CMD_V2) begin
            clear_line();
            return;
        end
        val    = minus_seen ? -longint'(value_acc) : longint'(value_acc);
        counts = 18'(val * COUNTS_PER_NS);
        clear_line();

        case (cmd)
            CMD_RT:  apply_ratio(16'(val));
            CMD_Z1:  width_lo = counts;
            CMD_Z2:  width_hi = counts;
            CMD_D1:  delay_lo = counts;
            CMD_D2:  delay_hi = counts;
            CMD_T1:  trail_lo = counts;
            CMD_T2:  trail_hi = counts;
            default: ;
        endcase

        bs = longint'($signed(base_count));
        wl = longint'($signed(width_lo));
        wh = longint'($signed(width_hi));
        dl = longint'($signed(delay_lo));
        dh = longint'($signed(delay_hi));
        tl = longint'($signed(trail_lo));
        th = longint'($signed(trail_hi));

        snap.status                = (cmd == CMD_ST);
        snap.fields.pad            = '0;
        snap.fields.ratio          = ratio_reg;
        snap.fields.compare_a1     = width_lo;
        snap.fields.compare_a2     = 19'(wl + dl);
        snap.fields.compare_a3     = 24'(PERIOD_COUNT - bs + tl);
        snap.fields.compare_b1     = width_hi;
        snap.fields.compare_b2     = 19'(wh + dh);
        snap.fields.compare_b3     = 24'(bs + th);
        snap.fields.compare_master = 24'(PERIOD_COUNT - bs);
        snapshots_due.push_back(snap);
    endfunction

    function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        ctcp_result_t got;
        snapshot_t    want;
        if (!aresetn) begin
            timing_reset();
            snapshots_due.delete();
        end else begin
            // Result side first: a result never belongs to a byte of the same edge
            if (m_tvalid && m_tready) begin
                results++;
                if (snapshots_due.size() == 0) begin
                    $error("result transfer with no snapshot pending");
                    errors++;
                end else begin
                    want = snapshots_due.pop_front();
                    got  = m_tdata;
                    check_field("status", 64'(want.status), 64'(m_tuser[0]));
                    check_field("ratio", 64'(want.fields.ratio), 64'(got.ratio));
                    check_field("compare_a1", 64'(want.fields.compare_a1),
                                64'(got.compare_a1));
                    check_field("compare_a2", 64'(want.fields.compare_a2),
                                64'(got.compare_a2));
                    check_field("compare_a3", 64'(want.fields.compare_a3),
                                64'(got.compare_a3));
                    check_field("compare_b1", 64'(want.fields.compare_b1),
                                64'(got.compare_b1));
                    check_field("compare_b2", 64'(want.fields.compare_b2),
                                64'(got.compare_b2));
                    check_field("compare_b3", 64'(want.fields.compare_b3),
                                64'(got.compare_b3));
                    check_field("compare_master", 64'(want.fields.compare_master),
                                64'(got.compare_master));
                    check_field("zero fill", 64'(want.fields.pad), 64'(got.pad));
                end
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
        end
        error_count   <= errors;
        pending_count <= snapshots_due.size();
        result_count  <= results;
    end

endmodule

FILE: sim/tb_console_timing_command_parser.sv
`timescale 1ns / 100ps

module tb_console_timing_command_parser;
    import ctcp_pkg::*;

    localparam int PERIOD_COUNT  = 16384;
    localparam int COUNTS_PER_NS = 4;
    localparam int MAX_LINE      = 48;
    localparam int BYTE_TARGET   = 600;
    localparam int CYCLE_LIMIT   = 400000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    int error_count;
    int pending_count;
    int result_count;

    logic [7:0] line_bytes[$];
    int         bytes_sent   = 0;
    int         lines_sent   = 0;
    int         long_lines   = 0;
    int         burst_left   = 0;
    int         cycle_count  = 0;
    int         stall_mode   = 0;

    string mnemonics[10] = '{"st", "rt", "z1", "z2", "d1", "d2", "t1", "t2", "v1", "v2"};

    console_timing_command_parser #(
        .PERIOD_COUNT  (PERIOD_COUNT),
        .COUNTS_PER_NS (COUNTS_PER_NS),
        .MAX_LINE      (MAX_LINE)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ctcp_timing_checker #(
        .PERIOD_COUNT  (PERIOD_COUNT),
        .COUNTS_PER_NS (COUNTS_PER_NS),
        .MAX_LINE      (MAX_LINE)
    ) timing_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall behavior changes between randomly picked modes
    always @(posedge aclk) begin
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycle_count % 16) < 3;
        endcase
    end

    // One byte transfer; the sender may idle between bursts of random length
    task automatic send_char(logic [7:0] c, logic eol);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_char(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
        lines_sent++;
    endtask

    task automatic push_blank();
        case ($urandom_range(0, 3))
            0:       line_bytes.push_back(CH_SPACE);
            1:       line_bytes.push_back(CH_TAB);
            2:       line_bytes.push_back(CH_CR);
            default: line_bytes.push_back(CH_LF);
        endcase
    endtask

    // Well-formed command with random value, blanks and trailing junk
    task automatic push_command();
        int n;
        repeat ($urandom_range(0, 2)) push_blank();
        push_text(mnemonics[$urandom_range(0, 9)]);
        line_bytes.push_back(CH_EQUAL);
        if ($urandom_range(0, 2) == 0)
            line_bytes.push_back(CH_MINUS);
        case ($urandom_range(0, 9))
            0:       n = $urandom_range(32768, 999999);
            1:       n = $urandom_range(0, 1) ? 32767 : 0;
            default: n = $urandom_range(0, 999);
        endcase
        push_text($sformatf("%0d", n));
        if ($urandom_range(0, 3) == 0) begin
            push_blank();
            repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: status of reset values, negative ratio, saturated width after a
        // leading tab, voltage command cut by NUL, lone high byte with no command
        push_text("st=");
        send_line();
        push_text("rt=-7");
        send_line();
        push_text("\tz1=99999");
        send_line();
        push_text("v1=");
        line_bytes.push_back(CH_NUL);
        send_line();
        line_bytes.push_back(8'hFF);
        send_line();

        // Random lines: mostly well-formed, some noise, broken and overlong lines
        while (bytes_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 12) begin
                repeat ($urandom_range(40, 50)) push_blank();
                push_command();
                long_lines++;
            end else if (pick < 27) begin
                push_command();
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            end else begin
                push_command();
            end
            send_line();
        end
        s_tvalid <= 1'b0;

        // Drain: the checker's pending count is a registered copy and lags behind its queue
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Covered %0d console bytes in %0d lines (%0d overlong)",
                 bytes_sent, lines_sent, long_lines);
        $display("Compared %0d result transfers", result_count);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
